>>> src/rcb_pkg.sv
package rcb_pkg;

  localparam int GRID_SIZE = 64;
  localparam int ROW_W     = $clog2(GRID_SIZE);
  localparam int COORD_W   = 7;
  localparam int CMP_W     = (ROW_W + 1 > COORD_W) ? ROW_W + 1 : COORD_W;

  localparam logic CMD_MARK  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic [GRID_SIZE-1:0] row_t;
  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [ROW_W-1:0]     row_idx_t;

  typedef struct packed {
    logic mark;
    logic hit;
  } rowop_ctrl_t;

endpackage

>>> src/rectangle_coverage_bitmap.sv
// Rectangle coverage bitmap over a square grid of one-bit cells.
// Input channel (in_valid/in_ready): one word per command. A mark word
// sets every cell of the half-open rectangle [x_low,x_high) by
// [y_low,y_high); it yields no result. A query word yields one result
// word on the output channel (out_valid/out_ready) whose fully_covered
// bit is set when every cell of the rectangle is set. Empty rectangles
// query as covered; a non-empty query reaching past the grid is not.
// The grid rows sit in a ring of row cells that rotates by one row per
// cycle, unless held, while a word is processed. A pass makes one ring
// step per row; in_ready is low during the pass and rises on the cycle
// after it, so no new word is accepted until the pass is done. A query
// result shows on out_valid when its pass ends. A finished result waits
// in an output register while the next word is accepted. If a query
// pass ends while the previous result is still stalled by out_ready,
// the ring holds its last step until the result is taken. Synchronous
// reset clears every cell and empties the output.
module rectangle_coverage_bitmap (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_command,
  input  logic [6:0]            in_x_low,
  input  logic [6:0]            in_y_low,
  input  logic [6:0]            in_x_high,
  input  logic [6:0]            in_y_high,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_fully_covered
);

  localparam int GS   = rcb_pkg::GRID_SIZE;
  localparam int RW   = rcb_pkg::ROW_W;
  localparam int CW   = rcb_pkg::CMP_W;

  logic                 busy_r, busy_nxt;
  rcb_pkg::row_idx_t    cnt_r, cnt_nxt;
  logic                 cmd_r, cmd_nxt;
  rcb_pkg::row_t        mask_r, mask_nxt;
  logic [CW-1:0]        ylo_r, ylo_nxt;
  logic [CW-1:0]        yhi_r, yhi_nxt;
  logic                 oob_r, oob_nxt;
  logic                 fail_r, fail_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_fc_r, out_fc_nxt;

  logic                 in_fire;
  logic                 last;
  logic                 hold;
  logic                 shift_en;
  rcb_pkg::row_idx_t    row_idx;
  logic [CW-1:0]        row_ext;
  logic [CW-1:0]        xl_ext, xh_ext, yl_ext, yh_ext;
  rcb_pkg::row_t        new_mask;
  rcb_pkg::rowop_ctrl_t op_ctrl;
  rcb_pkg::row_t        op_row;
  logic                 miss;
  rcb_pkg::row_t        cell_row [GS];

  assign in_ready = !busy_r;
  assign in_fire  = in_valid && in_ready;

  assign xl_ext = CW'(in_x_low);
  assign xh_ext = CW'(in_x_high);
  assign yl_ext = CW'(in_y_low);
  assign yh_ext = CW'(in_y_high);

  always_comb begin
    for (int c = 0; c < GS; c++) begin
      new_mask[c] = (CW'(c) >= xl_ext) && (CW'(c) < xh_ext);
    end
  end

  assign last     = (cnt_r == RW'(GS - 1));
  assign row_idx  = RW'(GS - 1) - cnt_r;
  assign row_ext  = CW'(row_idx);
  assign hold     = last && (cmd_r == rcb_pkg::CMD_QUERY) && out_valid_r && !out_ready;
  assign shift_en = busy_r && !hold;

  assign op_ctrl.mark = (cmd_r == rcb_pkg::CMD_MARK);
  assign op_ctrl.hit  = busy_r && (row_ext >= ylo_r) && (row_ext < yhi_r);

  rcb_row_op u_row_op (
    .ctrl     (op_ctrl),
    .col_mask (mask_r),
    .row_in   (cell_row[GS-1]),
    .row_out  (op_row),
    .miss     (miss)
  );

  for (genvar i = 0; i < GS; i++) begin : g_ring
    if (i == 0) begin : g_head
      rcb_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .row_in   (op_row),
        .row_out  (cell_row[i])
      );
    end else begin : g_body
      rcb_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .row_in   (cell_row[i-1]),
        .row_out  (cell_row[i])
      );
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    mask_nxt      = mask_r;
    ylo_nxt       = ylo_r;
    yhi_nxt       = yhi_r;
    oob_nxt       = oob_r;
    fail_nxt      = fail_r;
    out_valid_nxt = out_valid_r;
    out_fc_nxt    = out_fc_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_fire) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      cmd_nxt  = in_command;
      mask_nxt = new_mask;
      ylo_nxt  = yl_ext;
      yhi_nxt  = yh_ext;
      oob_nxt  = (xh_ext > xl_ext) && (yh_ext > yl_ext) &&
                 ((xh_ext > CW'(GS)) || (yh_ext > CW'(GS)));
      fail_nxt = 1'b0;
    end else if (shift_en) begin
      fail_nxt = fail_r | miss;
      cnt_nxt  = cnt_r + RW'(1);
      if (last) begin
        busy_nxt = 1'b0;
        if (cmd_r == rcb_pkg::CMD_QUERY) begin
          out_valid_nxt = 1'b1;
          out_fc_nxt    = !(fail_r || miss || oob_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    mask_r   <= mask_nxt;
    ylo_r    <= ylo_nxt;
    yhi_r    <= yhi_nxt;
    oob_r    <= oob_nxt;
    fail_r   <= fail_nxt;
    out_fc_r <= out_fc_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_fully_covered = out_fc_r;

endmodule

>>> src/rcb_cell.sv
module rcb_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  rcb_pkg::row_t row_in,
  output rcb_pkg::row_t row_out
);

  rcb_pkg::row_t row_r;
  rcb_pkg::row_t row_nxt;

  always_comb begin
    row_nxt = row_r;
    if (shift_en) begin
      row_nxt = row_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row_out = row_r;

endmodule

>>> src/rcb_row_op.sv
module rcb_row_op (
  input  rcb_pkg::rowop_ctrl_t ctrl,
  input  rcb_pkg::row_t        col_mask,
  input  rcb_pkg::row_t        row_in,
  output rcb_pkg::row_t        row_out,
  output logic                 miss
);

  always_comb begin
    row_out = row_in;
    miss    = 1'b0;
    if (ctrl.hit) begin
      if (ctrl.mark) begin
        row_out = row_in | col_mask;
      end else begin
        miss = ((row_in & col_mask) != col_mask);
      end
    end
  end

endmodule

>>> src/rcb_checker.sv
module rcb_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_fully_covered
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fully_covered))
    else $error("Stalled result word changed or dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Input ready right after an accepted word.");

  a_result_after_pass: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("Result word appeared without a pass in progress.");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("Block not idle and empty after reset.");

endmodule

bind rectangle_coverage_bitmap rcb_checker u_rcb_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_fully_covered (out_fully_covered)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps

class coverage_scoreboard;
  rcb_pkg::row_t cells [rcb_pkg::GRID_SIZE];
  logic expected_flags [$];
  int failures;
  int results_checked;

  function new();
    foreach (cells[r]) begin
      cells[r] = '0;
    end
    failures = 0;
    results_checked = 0;
  endfunction

  function void set_rectangle(int xl, int yl, int xh, int yh);
    if (xh > rcb_pkg::GRID_SIZE) begin
      xh = rcb_pkg::GRID_SIZE;
    end
    if (yh > rcb_pkg::GRID_SIZE) begin
      yh = rcb_pkg::GRID_SIZE;
    end
    for (int r = yl; r < yh; r++) begin
      for (int c = xl; c < xh; c++) begin
        cells[r][c] = 1'b1;
      end
    end
  endfunction

  function logic rectangle_covered(int xl, int yl, int xh, int yh);
    rcb_pkg::row_t mask;
    if (xh <= xl || yh <= yl) begin
      return 1'b1;
    end
    if (xh > rcb_pkg::GRID_SIZE || yh > rcb_pkg::GRID_SIZE) begin
      return 1'b0;
    end
    mask = '0;
    for (int c = xl; c < xh; c++) begin
      mask[c] = 1'b1;
    end
    for (int r = yl; r < yh; r++) begin
      if ((cells[r] & mask) != mask) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function void note_word(logic cmd, rcb_pkg::coord_t xl, rcb_pkg::coord_t yl,
                          rcb_pkg::coord_t xh, rcb_pkg::coord_t yh);
    if (cmd == rcb_pkg::CMD_MARK) begin
      set_rectangle(xl, yl, xh, yh);
    end else begin
      expected_flags.push_back(rectangle_covered(xl, yl, xh, yh));
    end
  endfunction

  function int pending();
    return expected_flags.size();
  endfunction

  task report_mismatch(string what);
    $display("%0t ns: %s", $time, what);
    failures++;
  endtask

  task check_result(logic got);
    logic want;
    if (expected_flags.size() == 0) begin
      report_mismatch($sformatf("result word with no query waiting, fully_covered=%0b", got));
    end else begin
      want = expected_flags.pop_front();
      if (got !== want) begin
        report_mismatch($sformatf("query %0d: fully_covered=%0b, expected %0b",
                                  results_checked, got, want));
      end
    end
    results_checked++;
  endtask
endclass

module testbench;

  typedef struct {
    rcb_pkg::coord_t xl;
    rcb_pkg::coord_t yl;
    rcb_pkg::coord_t xh;
    rcb_pkg::coord_t yh;
  } rect_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic            in_command = rcb_pkg::CMD_MARK;
  rcb_pkg::coord_t in_x_low = '0;
  rcb_pkg::coord_t in_y_low = '0;
  rcb_pkg::coord_t in_x_high = '0;
  rcb_pkg::coord_t in_y_high = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic            out_fully_covered;

  coverage_scoreboard sb;
  rect_t recent_marks [$];
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;

  rectangle_coverage_bitmap dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_x_low(in_x_low),
    .in_y_low(in_y_low),
    .in_x_high(in_x_high),
    .in_y_high(in_y_high),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_fully_covered(out_fully_covered)
  );

  always #4 clk = ~clk;

  task send_word(logic cmd, int xl, int yl, int xh, int yh);
    int gap;
    rect_t m;
    if ($urandom_range(0, 99) == 0) begin
      sender_idles = ~sender_idles;
    end
    gap = sender_idles ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_x_low <= rcb_pkg::coord_t'(xl);
    in_y_low <= rcb_pkg::coord_t'(yl);
    in_x_high <= rcb_pkg::coord_t'(xh);
    in_y_high <= rcb_pkg::coord_t'(yh);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(cmd, rcb_pkg::coord_t'(xl), rcb_pkg::coord_t'(yl),
                 rcb_pkg::coord_t'(xh), rcb_pkg::coord_t'(yh));
    if (cmd == rcb_pkg::CMD_MARK && xh > xl && yh > yl &&
        xh <= rcb_pkg::GRID_SIZE && yh <= rcb_pkg::GRID_SIZE) begin
      m.xl = rcb_pkg::coord_t'(xl);
      m.yl = rcb_pkg::coord_t'(yl);
      m.xh = rcb_pkg::coord_t'(xh);
      m.yh = rcb_pkg::coord_t'(yh);
      recent_marks.push_back(m);
      if (recent_marks.size() > 32) begin
        void'(recent_marks.pop_front());
      end
    end
  endtask

  task wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task send_directed();
    send_word(rcb_pkg::CMD_QUERY, 0, 0, 64, 64);
    send_word(rcb_pkg::CMD_QUERY, 0, 0, 1, 1);
    send_word(rcb_pkg::CMD_QUERY, 5, 5, 5, 9);
    send_word(rcb_pkg::CMD_QUERY, 9, 5, 3, 9);
    send_word(rcb_pkg::CMD_QUERY, 64, 64, 64, 64);
    send_word(rcb_pkg::CMD_MARK, 10, 10, 10, 20);
    send_word(rcb_pkg::CMD_MARK, 20, 10, 30, 5);
    send_word(rcb_pkg::CMD_QUERY, 10, 10, 11, 11);
    send_word(rcb_pkg::CMD_MARK, 0, 0, 64, 1);
    send_word(rcb_pkg::CMD_QUERY, 0, 0, 64, 1);
    send_word(rcb_pkg::CMD_QUERY, 0, 0, 64, 2);
    send_word(rcb_pkg::CMD_QUERY, 0, 0, 65, 1);
    send_word(rcb_pkg::CMD_MARK, 60, 60, 127, 127);
    send_word(rcb_pkg::CMD_QUERY, 60, 60, 64, 64);
    send_word(rcb_pkg::CMD_QUERY, 63, 63, 64, 64);
    send_word(rcb_pkg::CMD_QUERY, 60, 60, 64, 65);
    send_word(rcb_pkg::CMD_MARK, 100, 100, 127, 127);
    send_word(rcb_pkg::CMD_QUERY, 100, 100, 120, 120);
    send_word(rcb_pkg::CMD_QUERY, 127, 0, 127, 1);
    send_word(rcb_pkg::CMD_MARK, 0, 0, 64, 64);
    send_word(rcb_pkg::CMD_QUERY, 0, 0, 64, 64);
    send_word(rcb_pkg::CMD_QUERY, 0, 0, 127, 127);
  endtask

  task send_random_word();
    int kind;
    int xl;
    int yl;
    int xh;
    int yh;
    rect_t m;
    kind = $urandom_range(0, 99);
    xl = $urandom_range(0, 63);
    yl = $urandom_range(0, 63);
    if (kind < 5) begin
      send_word(logic'($urandom_range(0, 1)), $urandom_range(0, 127), $urandom_range(0, 127),
                $urandom_range(0, 127), $urandom_range(0, 127));
    end else if (kind < 10) begin
      xh = $urandom_range(0, 64);
      yh = $urandom_range(0, 64);
      if ($urandom_range(0, 1)) begin
        xl = $urandom_range(xh, 64);
      end else begin
        yl = $urandom_range(yh, 64);
      end
      send_word(logic'($urandom_range(0, 1)), xl, yl, xh, yh);
    end else if (kind < 50) begin
      xh = xl + $urandom_range(1, 4);
      yh = yl + $urandom_range(1, 4);
      send_word(rcb_pkg::CMD_MARK, xl, yl, (xh > 64) ? 64 : xh, (yh > 64) ? 64 : yh);
    end else if (kind < 70 && recent_marks.size() > 0) begin
      m = recent_marks[$urandom_range(0, recent_marks.size() - 1)];
      xl = $urandom_range(m.xl, m.xh - 1);
      yl = $urandom_range(m.yl, m.yh - 1);
      send_word(rcb_pkg::CMD_QUERY, xl, yl, $urandom_range(xl + 1, m.xh),
                $urandom_range(yl + 1, m.yh));
    end else if (kind < 85) begin
      xh = xl + $urandom_range(1, 3);
      yh = yl + $urandom_range(1, 3);
      send_word(rcb_pkg::CMD_QUERY, xl, yl, (xh > 64) ? 64 : xh, (yh > 64) ? 64 : yh);
    end else if (kind < 95) begin
      send_word(rcb_pkg::CMD_QUERY, xl, yl, $urandom_range(xl + 1, 64),
                $urandom_range(yl + 1, 64));
    end else begin
      send_word(rcb_pkg::CMD_QUERY, xl, yl, 64, $urandom_range(yl + 1, 65));
    end
  endtask

  task receive_words();
    int gap;
    forever begin
      if (sb.results_checked == 60 || sb.results_checked == 500) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        if ($urandom_range(0, 99) == 0) begin
          receiver_idles = ~receiver_idles;
        end
        gap = receiver_idles ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_fully_covered);
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      receive_words();
    join_none
    send_directed();
    wait_until_drained();
    for (int i = 0; i < 1750; i++) begin
      if (i == 900) begin
        wait_until_drained();
      end
      send_random_word();
    end
    wait_until_drained();
    repeat (200) @(posedge clk);
    if (sb.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("simulation failed");
    $finish;
  end
endmodule
